// ----- hdl/egcd_pkg.sv -----
package egcd_pkg;

	localparam int unsigned OPERAND_BITS = 63;
	localparam int unsigned COEF_BITS    = 64;
	localparam int unsigned IN_BYTES     = (2 * OPERAND_BITS + 7) / 8;
	localparam int unsigned OUT_BITS     = OPERAND_BITS + 2 * COEF_BITS;
	localparam int unsigned OUT_BYTES    = (OUT_BITS + 7) / 8;

	typedef logic [COEF_BITS-1:0] coef_t;

endpackage

// ----- hdl/extended_gcd.sv -----
// Extended Euclid: one transfer in, one transfer out with gcd and Bezout coefficients x, y
// (a*x + b*y = gcd, coefficients 64-bit two's complement). Each Euclid step starts a restoring
// divider and waits for its done strobe. It then forms two products on one shared 64x64
// mod-2^64 multiply, each done as four 32x32 partial products at one per cycle. An item
// takes at most about 90 Euclid steps at WIDTH 63. The block accepts no new item until the
// result has been taken.
module extended_gcd #(
	parameter int unsigned WIDTH = 63
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// operand_a[62:0], operand_b[125:63], zero pad
	input  logic [egcd_pkg::IN_BYTES*8-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// gcd_value[62:0], coef_x[126:63], coef_y[190:127], zero pad
	output logic [egcd_pkg::OUT_BYTES*8-1:0] m_tdata
);
	import egcd_pkg::*;

	typedef enum logic [2:0] {IDLE, DIV_START, DIV_WAIT, MUL, OUT} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] a_q, b_q;
	coef_t            xp_q, xc_q, yp_q, yc_q, acc_q, q_q;
	logic [2:0]       ph_q;
	logic             div_start, div_done;
	logic [WIDTH-1:0] quo, rem;
	logic [31:0]      mul_a, mul_b;
	logic [63:0]      prod;
	coef_t            term, mc;

	egcd_divider #(.WIDTH(WIDTH)) u_div (
		.clk, .arst_n, .start(div_start), .dividend(a_q), .divisor(b_q),
		.done(div_done), .quotient(quo), .remainder(rem)
	);

	// divider runs only when there is a nonzero divisor
	assign div_start = (state_q == DIV_START) && (b_q != '0);

	// shared 32x32 multiplier; phase bit2 picks x or y, bits1:0 the partial product
	assign mc    = ph_q[2] ? yc_q : xc_q;
	assign mul_a = ph_q[0] ? mc[63:32] : mc[31:0];
	assign mul_b = ph_q[1] ? q_q[63:32] : q_q[31:0];
	assign prod  = mul_a * mul_b;
	always_comb begin
		case (ph_q[1:0])
			2'd0:    term = prod;
			2'd1,
			2'd2:    term = {prod[31:0], 32'd0};
			default: term = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ph_q    <= '0;
		end else begin
			case (state_q)
				IDLE: if (s_tvalid) begin
					a_q  <= s_tdata[WIDTH-1:0];
					b_q  <= s_tdata[OPERAND_BITS+WIDTH-1:OPERAND_BITS];
					xp_q <= coef_t'(1);
					xc_q <= '0;
					yp_q <= '0;
					yc_q <= coef_t'(1);
					state_q <= DIV_START;
				end
				DIV_START: state_q <= (b_q == '0) ? OUT : DIV_WAIT;
				DIV_WAIT: if (div_done) begin
					q_q   <= COEF_BITS'(quo);
					acc_q <= '0;
					ph_q  <= '0;
					state_q <= MUL;
				end
				MUL: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q[1:0] == 2'd3) begin
						// finished one product: update the pair
						if (!ph_q[2]) begin
							xp_q  <= xc_q;
							xc_q  <= xp_q - (acc_q + term);
							acc_q <= '0;
						end else begin
							yp_q <= yc_q;
							yc_q <= yp_q - (acc_q + term);
							a_q  <= b_q;
							b_q  <= rem;
							state_q <= DIV_START;
						end
					end else begin
						acc_q <= acc_q + term;
					end
				end
				OUT: if (m_tready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUT);
	assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, yp_q, xp_q,
		OPERAND_BITS'(a_q)};

`ifndef SYNTH
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_out_zero_b: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> b_q == '0) else $error("result with nonzero divisor");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL |-> !s_tready && !m_tvalid) else $error("handshake during step");
`endif
endmodule

// ----- hdl/egcd_divider.sv -----
// restoring divider, one quotient bit per cycle
module egcd_divider #(
	parameter int unsigned WIDTH = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q, quo_q, div_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;

	// shift in next dividend bit and try subtracting
	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CW'(1) |=> !done_q) else $error("divider done early");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q) else $error("remainder not below divisor");
`endif
endmodule

// ----- tb/tb_extended_gcd.sv -----
`timescale 1ns / 1ps

module tb_extended_gcd;

	import egcd_pkg::*;

	localparam int unsigned W          = 63;
	localparam int unsigned WATCH_MAX  = 40000;
	localparam int unsigned DRAIN_WAIT = 200;

	typedef logic [OPERAND_BITS-1:0] operand_t;

	typedef struct packed {
		coef_t    y;
		coef_t    x;
		operand_t g;
	} egcd_res_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_BYTES*8-1:0]   s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_BYTES*8-1:0]  m_tdata;

	logic [IN_BYTES*8-1:0] pending_ops[$];
	egcd_res_t             expected_res[$];
	int unsigned           errors;
	int unsigned           send_idle_pct;
	int unsigned           recv_idle_pct;
	bit                    hold_send;
	bit                    timed_out;
	int unsigned           quiet_cycles;

	extended_gcd #(.WIDTH(W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// euclid with wrapping 64-bit coefficient pairs
	function automatic egcd_res_t bezout(input operand_t a_in, input operand_t b_in);
		logic [63:0] a, b, q, r, xp, xc, yp, yc, xn, yn;
		egcd_res_t res;
		a  = {1'b0, a_in} & ((64'd1 << W) - 64'd1);
		b  = {1'b0, b_in} & ((64'd1 << W) - 64'd1);
		xp = 64'd1;
		xc = 64'd0;
		yp = 64'd0;
		yc = 64'd1;
		while (b != 64'd0) begin
			q  = a / b;
			r  = a - q * b;
			xn = xp - q * xc;
			yn = yp - q * yc;
			a  = b;
			b  = r;
			xp = xc;
			xc = xn;
			yp = yc;
			yc = yn;
		end
		res.g = a[62:0];
		res.x = xp;
		res.y = yp;
		return res;
	endfunction

	function automatic operand_t rand_operand();
		operand_t v;
		int unsigned bits;
		v    = operand_t'({$urandom, $urandom});
		bits = $urandom_range(1, OPERAND_BITS);
		// mostly short operands, sometimes full width
		if ($urandom_range(0, 3) != 0)
			v = v & ((63'd1 << bits) - 63'd1);
		return v;
	endfunction

	task automatic push_pair(input operand_t a, input operand_t b);
		pending_ops.push_back({{(IN_BYTES*8 - 2*OPERAND_BITS){1'b0}}, b, a});
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("error: %s got %h expected %h", what, got, want);
		errors++;
	endtask

	// driver: one transfer per handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				void'(pending_ops.pop_front());
			if (s_tvalid && !s_tready) begin
				// hold the item
			end else if (hold_send || pending_ops.size() == 0 ||
					(s_tvalid && s_tready && pending_ops.size() == 0)) begin
				s_tvalid <= 1'b0;
			end else if ($urandom_range(0, 99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_ops[0];
			end
		end
	end

	// predict on accepted input transfer
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			expected_res.push_back(bezout(s_tdata[62:0], s_tdata[125:63]));
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		egcd_res_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_BITS-1:0];
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected result", {1'b0, got.g}, 64'd0);
				end else begin
					want = expected_res.pop_front();
					if (got.g !== want.g)
						report_mismatch("gcd_value", {1'b0, got.g}, {1'b0, want.g});
					if (got.x !== want.x)
						report_mismatch("coef_x", got.x, want.x);
					if (got.y !== want.y)
						report_mismatch("coef_y", got.y, want.y);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("extended_gcd: mismatch");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_ops.size() != 0 || s_tvalid || expected_res.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		operand_t a, b, k;
		hold_send     = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 54;
		arst_n        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// directed: zeros, extremes, equal, coprime, multiples, fibonacci
		push_pair(63'd0, 63'd0);
		push_pair(63'd0, 63'd17);
		push_pair(63'd25, 63'd0);
		push_pair('1, 63'd0);
		push_pair(63'd0, '1);
		push_pair('1, '1);
		push_pair('1, 63'd1);
		push_pair(63'd1, '1);
		push_pair('1, '1 - 63'd1);
		push_pair(63'd240, 63'd46);
		push_pair(63'd46, 63'd240);
		push_pair(63'd1, 63'd1);
		push_pair(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
		push_pair(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
		push_pair(63'd7540113804746346429, 63'd4660046610375530309);
		push_pair(63'd4660046610375530309, 63'd2880067194370816120);
		push_pair(63'd1000000007 * 63'd6, 63'd1000000007 * 63'd4);
		push_pair(63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000);

		// pause until every result is back
		wait_drained();
		hold_send = 1'b1;
		repeat (20) @(posedge clk);
		hold_send = 1'b0;

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
			recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
			for (int i = 0; i < 41; i++) begin
				a = rand_operand();
				b = rand_operand();
				// some pairs with a shared factor
				if ($urandom_range(0, 3) == 0) begin
					k = operand_t'($urandom_range(2, 1000));
					a = (a >> 12) * k;
					b = (b >> 12) * k;
				end
				if ($urandom_range(0, 15) == 0)
					b = 63'd0;
				push_pair(a, b);
			end
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0)
			$display("extended_gcd: match");
		else
			$display("extended_gcd: mismatch");
		$finish;
	end

endmodule
